>>> hdl/bgc_pkg.sv
// Shared types and constants for the bar gradient colour shader.
package bgc_pkg;

  // Number of colour guns and pipeline depth
  localparam int unsigned NGUN = 3;
  localparam int unsigned NS   = 13;

  // First stage and number of stages of the per-bit divider chain
  localparam int unsigned DIV_FIRST = 3;
  localparam int unsigned DIV_STEPS = 8;

  // Height floor and 1/15 reciprocal for the 4-bit rounding divide
  localparam logic [7:0]  MIN_HEIGHT = 8'd2;
  localparam logic [15:0] RECIP_15   = 16'd137;
  localparam int unsigned RECIP_15_SH = 11;

  // Configuration register indexes
  localparam logic REG_PALETTE_SELECT = 1'b0;
  localparam logic REG_BAR_HEIGHT     = 1'b1;

  // Base colours, 4 bits per gun, red in the top nibble
  localparam logic [11:0] BASE_TBL [4][8] = '{
    '{12'hF00, 12'hF80, 12'hFF0, 12'h0F0, 12'h0FF, 12'h08F, 12'h00F, 12'hF0F},
    '{12'hF00, 12'hF40, 12'hF80, 12'hFC0, 12'hFF0, 12'hF60, 12'hF20, 12'hFA0},
    '{12'h00F, 12'h06F, 12'h0AF, 12'h0FF, 12'h8FF, 12'h48F, 12'h26F, 12'h0CF},
    '{12'hFFF, 12'hCCC, 12'h999, 12'hEEE, 12'hBBB, 12'hDDD, 12'hAAA, 12'h888}
  };

  // Payload carried by every pipeline stage
  typedef struct packed {
    logic [7:0]             bar;
    logic [7:0]             bar_quot;
    logic [1:0]             pal;
    logic [7:0]             h;
    logic [7:0]             ctr_dist;
    logic [11:0]            base;
    logic [11:0]            rem_lev;
    logic [3:0]             quot_lev;
    logic [NGUN-1:0][15:0]  rem8;
    logic [NGUN-1:0][7:0]   quot8;
    logic [NGUN-1:0][7:0]   shade_x;
    logic [11:0]            c12;
    logic [23:0]            c24;
  } stage_t;

endpackage

>>> hdl/bgc_in_if.sv
// Request channel carrying one bar line to be shaded.
interface bgc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] bar_number;
  logic [7:0] line_in_bar;

  modport source (output valid, output bar_number, output line_in_bar, input ready);
  modport sink   (input valid, input bar_number, input line_in_bar, output ready);
endinterface

>>> hdl/bgc_out_if.sv
// Result channel carrying the shaded colour in two depths.
interface bgc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] colour_12bit;
  logic [23:0] colour_24bit;

  modport source (output valid, output colour_12bit, output colour_24bit, input ready);
  modport sink   (input valid, input colour_12bit, input colour_24bit, output ready);
endinterface

>>> hdl/bar_gradient_colour.sv
// Top level of the bar gradient colour shader pipeline.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    bar_number[7:0], line_in_bar[7:0]
//   out_ch    source     valid/ready    colour_12bit[11:0], colour_24bit[23:0]
//   cfg_*     sink       cfg_we only    cfg_index[0], cfg_data[7:0]
//
// One request per cycle sustained while out_ch is ready; the pipeline is the eight
// one-bit-per-stage divide steps by the bar height plus the setup and
// rounding stages around them.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// Each stage stalls only when it is full and the stage after it cannot take
// its request, so bubbles close up and no request is lost or repeated.
module bar_gradient_colour #(
  parameter int unsigned PALETTE_COUNT     = 4,
  parameter int unsigned BASES_PER_PALETTE = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  bgc_in_if.sink            in_ch,
  bgc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);
  import bgc_pkg::*;

  // Reciprocal for bar_number mod BASES_PER_PALETTE, exact for 8-bit inputs
  localparam int unsigned IDX_RECIP = (65536 + BASES_PER_PALETTE - 1) / BASES_PER_PALETTE;
  localparam logic [1:0]  PAL_LAST  = 2'(PALETTE_COUNT - 1);

  logic [1:0] palette_select_r;
  logic [7:0] bar_height_r;

  logic [NS-1:0] valid_r;
  logic [NS-1:0] adv;
  stage_t        pipe_r   [NS];
  stage_t        pipe_nxt [NS];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_select_r <= 2'd0;
      bar_height_r     <= 8'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PALETTE_SELECT: palette_select_r <= cfg_data[1:0];
        REG_BAR_HEIGHT:     bar_height_r     <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS-1] = !valid_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign in_ch.ready         = adv[0];
  assign out_ch.valid        = valid_r[NS-1];
  assign out_ch.colour_12bit = pipe_r[NS-1].c12;
  assign out_ch.colour_24bit = pipe_r[NS-1].c24;

  // Stage logic
  always_comb begin : stage_logic
    logic [7:0]  hc;
    logic [7:0]  line;
    logic [8:0]  twice;
    logic [8:0]  h9;
    logic [7:0]  rem;
    logic [2:0]  idx;
    logic [3:0]  b;
    logic [3:0]  lev;
    logic [3:0]  g4;
    logic [7:0]  g8;
    logic [15:0] d16;
    logic [11:0] d12;
    logic [15:0] prod;
    logic [24:0] qprod;
    logic [1:0]  sl;
    int          s;

    sl  = '0;
    d12 = '0;

    // Stage 0: clamp height and line, distance from center, palette, bar quotient
    pipe_nxt[0] = '0;
    hc = (bar_height_r < MIN_HEIGHT) ? MIN_HEIGHT : bar_height_r;
    line = (in_ch.line_in_bar >= hc) ? 8'(hc - 8'd1) : in_ch.line_in_bar;
    twice = {line, 1'b1};
    h9 = {1'b0, hc};
    pipe_nxt[0].ctr_dist = (twice >= h9) ? 8'(twice - h9) : 8'(h9 - twice);
    pipe_nxt[0].h = hc;
    pipe_nxt[0].pal = (32'(palette_select_r) >= PALETTE_COUNT) ? PAL_LAST : palette_select_r;
    pipe_nxt[0].bar = in_ch.bar_number;
    qprod = 25'(in_ch.bar_number) * 25'(IDX_RECIP);
    pipe_nxt[0].bar_quot = qprod[23:16];

    // Stage 1: base colour lookup
    pipe_nxt[1] = pipe_r[0];
    rem = 8'(pipe_r[0].bar - 8'(16'(pipe_r[0].bar_quot) * 16'(BASES_PER_PALETTE)));
    idx = rem[2:0];
    pipe_nxt[1].base = BASE_TBL[pipe_r[0].pal][idx];

    // Stage 2: dividends for level and 8-bit shades
    pipe_nxt[2] = pipe_r[1];
    pipe_nxt[2].rem_lev = 12'(pipe_r[1].ctr_dist) * 12'd15;
    pipe_nxt[2].quot_lev = '0;
    for (int g = 0; g < NGUN; g++) begin
      b = pipe_r[1].base[11-4*g -: 4];
      pipe_nxt[2].rem8[g]  = 16'({b, b}) * 16'(8'(pipe_r[1].h - pipe_r[1].ctr_dist));
      pipe_nxt[2].quot8[g] = '0;
    end

    // Stages 3 to 10: one quotient bit each, by the bar height
    for (int j = 0; j < DIV_STEPS; j++) begin
      s = DIV_STEPS - 1 - j;
      pipe_nxt[DIV_FIRST+j] = pipe_r[DIV_FIRST+j-1];
      d16 = 16'(pipe_r[DIV_FIRST+j-1].h) << s;
      for (int g = 0; g < NGUN; g++) begin
        if (pipe_r[DIV_FIRST+j-1].rem8[g] >= d16) begin
          pipe_nxt[DIV_FIRST+j].rem8[g]     = pipe_r[DIV_FIRST+j-1].rem8[g] - d16;
          pipe_nxt[DIV_FIRST+j].quot8[g][s] = 1'b1;
        end
      end
      // level quotient is below 16, so only the last four steps apply
      if (s <= 3) begin
        sl  = 2'(s);
        d12 = 12'(pipe_r[DIV_FIRST+j-1].h) << s;
        if (pipe_r[DIV_FIRST+j-1].rem_lev >= d12) begin
          pipe_nxt[DIV_FIRST+j].rem_lev      = pipe_r[DIV_FIRST+j-1].rem_lev - d12;
          pipe_nxt[DIV_FIRST+j].quot_lev[sl] = 1'b1;
        end
      end
    end

    // Stage 11: scale each 4-bit gun by the level, with rounding bias
    pipe_nxt[NS-2] = pipe_r[NS-3];
    lev = 4'd15 - pipe_r[NS-3].quot_lev;
    for (int g = 0; g < NGUN; g++) begin
      b = pipe_r[NS-3].base[11-4*g -: 4];
      pipe_nxt[NS-2].shade_x[g] = (8'(b) * 8'(lev)) + 8'd7;
    end

    // Stage 12: divide by 15, brighten the peak level, pack the colours
    pipe_nxt[NS-1] = pipe_r[NS-2];
    for (int g = 0; g < NGUN; g++) begin
      prod = 16'(pipe_r[NS-2].shade_x[g]) * RECIP_15;
      g4 = 4'(prod >> RECIP_15_SH);
      g8 = pipe_r[NS-2].quot8[g];
      if (pipe_r[NS-2].quot_lev == 4'd0) begin
        g4 = g4 + ((4'd15 - g4) >> 1);
        g8 = g8 + ((8'd255 - g8) >> 1);
      end
      pipe_nxt[NS-1].c12[11-4*g -: 4] = g4;
      pipe_nxt[NS-1].c24[23-8*g -: 8] = g8;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) begin
        valid_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Advance payload; hold it while a stage stalls
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (adv[k]) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

endmodule

>>> tb/tb_bar_gradient_colour.sv
// Testbench for bar_gradient_colour: directed and random bar lines checked against a shade predictor.
module tb_bar_gradient_colour;
  timeunit 1ns;
  timeprecision 1ps;

  import bgc_pkg::*;

  // Pipeline depth quoted by the block, used for settle time after draining
  localparam int unsigned PIPE_LATENCY = 13;
  localparam int unsigned IDLE_PCT     = 19;
  localparam int unsigned HOLD_CYCLES  = 80;

  // Palette codes as written to the palette register
  localparam logic [1:0] PAL_RAINBOW = 2'd0;
  localparam logic [1:0] PAL_FIRE    = 2'd1;
  localparam logic [1:0] PAL_ICE     = 2'd2;
  localparam logic [1:0] PAL_MONO    = 2'd3;

  // Base colours per palette, 4 bits per gun, red on top
  localparam logic [11:0] BAR_BASES [4][8] = '{
    '{12'hF00, 12'hF80, 12'hFF0, 12'h0F0, 12'h0FF, 12'h08F, 12'h00F, 12'hF0F},
    '{12'hF00, 12'hF40, 12'hF80, 12'hFC0, 12'hFF0, 12'hF60, 12'hF20, 12'hFA0},
    '{12'h00F, 12'h06F, 12'h0AF, 12'h0FF, 12'h8FF, 12'h48F, 12'h26F, 12'h0CF},
    '{12'hFFF, 12'hCCC, 12'h999, 12'hEEE, 12'hBBB, 12'hDDD, 12'hAAA, 12'h888}
  };

  typedef struct packed {
    logic [11:0] c12;
    logic [23:0] c24;
  } shade_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  // Predictor copy of the configuration
  logic [1:0] cur_palette = PAL_RAINBOW;
  logic [7:0] cur_height  = 8'd16;

  shade_t      pending_shades [$];
  int unsigned fail_count  = 0;
  logic        flow_steady = 1'b0;
  logic        out_hold    = 1'b0;

  bgc_in_if  in_if ();
  bgc_out_if out_if ();

  bar_gradient_colour DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the expected shade for one bar line under the current settings
  function automatic shade_t predict_shade(logic [7:0] bar, logic [7:0] line);
    int unsigned h, ln, twice, ctr_dist, lev, b, g, g8, sh4, sh8;
    logic [11:0] base;
    shade_t      s;
    h        = (cur_height < 8'd2) ? 2 : 32'(cur_height);
    base     = BAR_BASES[cur_palette][bar[2:0]];
    ln       = (32'(line) >= h) ? h - 1 : 32'(line);
    twice    = 2 * ln + 1;
    ctr_dist = (twice >= h) ? twice - h : h - twice;
    lev      = 15 - (ctr_dist * 15) / h;
    s        = '0;
    for (int gun = 0; gun < 3; gun++) begin
      sh4 = 8 - 4 * gun;
      sh8 = 16 - 8 * gun;
      b   = (32'(base) >> sh4) & 15;
      g   = (b * lev + 7) / 15;
      g8  = (b * 17 * (h - ctr_dist)) / h;
      // Brightest level: push halfway toward white
      if (lev == 15) begin
        g  = g + (15 - g) / 2;
        g8 = g8 + (255 - g8) / 2;
      end
      s.c12 = s.c12 | 12'((g & 15) << sh4);
      s.c24 = s.c24 | 24'((g8 & 255) << sh8);
    end
    return s;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    fail_count++;
  endtask

  // Offer one request, idle at random first, and log its expected shade once taken
  task automatic send_request(logic [7:0] bar, logic [7:0] line);
    while (!flow_steady && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.bar_number  <= bar;
    in_if.line_in_bar <= line;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_shades.insert(pending_shades.size(), predict_shade(bar, line));
  endtask

  task automatic send_random_request();
    int unsigned h;
    logic [7:0]  line;
    h = (cur_height < 8'd2) ? 2 : 32'(cur_height);
    // Mostly lines inside the bar, some anywhere to hit the clamp
    if ($urandom_range(99) < 80) line = 8'($urandom_range(h - 1));
    else line = 8'($urandom_range(255));
    send_request(8'($urandom_range(255)), line);
  endtask

  // Drop valid and wait until every expected shade has come back
  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    while (pending_shades.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Write both registers while the pipeline is empty
  task automatic apply_bar_config(logic [1:0] pal, logic [7:0] height);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= REG_PALETTE_SELECT;
    cfg_data  <= {6'd0, pal};
    @(posedge clk);
    cfg_index <= REG_BAR_HEIGHT;
    cfg_data  <= height;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_palette = pal;
    cur_height  = height;
  endtask

  // Hold the result side off for a fixed count of cycles
  task automatic hold_results(int unsigned cycles);
    out_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    out_hold <= 1'b0;
  endtask

  // Check each returned colour against the oldest expectation, then pick next ready
  initial begin
    shade_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        if (pending_shades.size() == 0) begin
          report_mismatch($sformatf("colour %h/%h with no request outstanding",
                                    out_if.colour_12bit, out_if.colour_24bit));
        end else begin
          want = pending_shades.pop_front();
          if (out_if.colour_12bit !== want.c12)
            report_mismatch($sformatf("colour_12bit expected %h got %h",
                                      want.c12, out_if.colour_12bit));
          if (out_if.colour_24bit !== want.c24)
            report_mismatch($sformatf("colour_24bit expected %h got %h",
                                      want.c24, out_if.colour_24bit));
        end
      end
      out_if.ready <= !out_hold && (flow_steady || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Reset defaults: every base entry of the rainbow palette at the bar centre
  task automatic test_default_palette();
    for (int i = 0; i < 8; i++) send_request(8'(i), 8'd7);
  endtask

  // Field extremes, including a line far past the bar and the last line
  task automatic test_field_extremes();
    send_request(8'd255, 8'd0);
    send_request(8'd0, 8'd255);
    send_request(8'd248, 8'd15);
    send_request(8'd7, 8'd16);
  endtask

  // Heights of zero and one behave as a two-line bar
  task automatic test_height_floor();
    apply_bar_config(PAL_FIRE, 8'd0);
    send_request(8'd3, 8'd0);
    send_request(8'd3, 8'd1);
    apply_bar_config(PAL_ICE, 8'd1);
    send_request(8'd5, 8'd0);
    send_request(8'd5, 8'd255);
  endtask

  // Tallest bar: exact centre, edges and clamp
  task automatic test_tall_bar();
    apply_bar_config(PAL_MONO, 8'd255);
    send_request(8'd128, 8'd127);
    send_request(8'd1, 8'd254);
    send_request(8'd2, 8'd0);
    send_request(8'd255, 8'd255);
  endtask

  // Random lines through a series of settings, extremes first
  task automatic test_random_settings();
    logic [1:0] pal;
    logic [7:0] height;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin pal = PAL_RAINBOW; height = 8'd2;   end
        1: begin pal = PAL_MONO;    height = 8'd255; end
        2: begin pal = PAL_FIRE;    height = 8'd2;   end
        3: begin pal = PAL_ICE;     height = 8'd255; end
        default: begin
          pal    = 2'($urandom_range(3));
          height = 8'($urandom_range(255, 2));
        end
      endcase
      apply_bar_config(pal, height);
      repeat (45) send_random_request();
    end
  endtask

  // Back-to-back requests with the result side always ready
  task automatic test_steady_flow();
    apply_bar_config(PAL_RAINBOW, 8'($urandom_range(40, 8)));
    flow_steady <= 1'b1;
    repeat (50) send_random_request();
    drain_pipeline();
    flow_steady <= 1'b0;
  endtask

  // Stall the results long enough that the pipeline fills and blocks input
  task automatic test_backpressure();
    apply_bar_config(PAL_ICE, 8'($urandom_range(64, 2)));
    fork
      hold_results(HOLD_CYCLES);
    join_none
    repeat (40) send_random_request();
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_PALETTE_SELECT;
    cfg_data          <= 8'd0;
    in_if.valid       <= 1'b0;
    in_if.bar_number  <= 8'd0;
    in_if.line_in_bar <= 8'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_palette();
    test_field_extremes();
    test_height_floor();
    test_tall_bar();
    test_random_settings();
    test_steady_flow();
    test_backpressure();
    drain_pipeline();

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2ms;
    $display("%0t ERROR timeout with %0d colours outstanding", $time, pending_shades.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
